// ----- hw/rtl/nrhe_pkg.sv -----
// Package for the neuron route hop expander.
// Holds shared constants, configuration register indexes and port codes.
// No dependencies.
package nrhe_pkg;
    localparam int MAX_POPULATIONS = 16;
    localparam int MAX_MESH_DIM = 16;
    localparam int NEURON_ID_BITS = 20;
    localparam int MAX_PES_PER_TILE = 64;
    localparam int MAX_NPE = 65536;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MESH_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PES_PER_TILE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEURONS_PER_PE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TORUS_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POP_COUNT = 3'd5;

    localparam logic [6:0] PORT_NORTH = 7'd0;
    localparam logic [6:0] PORT_EAST = 7'd1;
    localparam logic [6:0] PORT_SOUTH = 7'd2;
    localparam logic [6:0] PORT_WEST = 7'd3;
    localparam logic [6:0] PORT_LOCAL = 7'd4;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_ROUTE = 1'b1;
endpackage

// ----- hw/rtl/nrhe_ram.sv -----
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module nrhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/neuron_route_hop_expander_top.sv -----
// A load item runs through the states LD_RD, LD_WAIT, LD_DIV and LD_WR before the next transfer.
// A route item gives its first result after the scans, the divisions and the hop plan, then
// one result per cycle while the receiver is ready; the next transfer follows the last result.
// Throughput: one item at a time, set by the population scans, the shared restoring divider
// (one quotient bit per cycle) and the hop walk. Reset: aresetn, synchronous and active low,
// clears control state and restores register defaults; the population tables stay undefined.
module neuron_route_hop_expander_top #(
    parameter int MAX_POPULATIONS = nrhe_pkg::MAX_POPULATIONS,
    parameter int MAX_MESH_DIM = nrhe_pkg::MAX_MESH_DIM,
    parameter int NEURON_ID_BITS = nrhe_pkg::NEURON_ID_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [nrhe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nrhe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [3:0]                         s_pop_index,
    input  logic [19:0]                        s_pop_first_id,
    input  logic [19:0]                        s_pop_last_id,
    input  logic [19:0]                        s_src_neuron,
    input  logic [19:0]                        s_dst_neuron,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_tile_index,
    output logic [19:0]                        m_key_neuron,
    output logic [6:0]                         m_out_port,
    output logic                               m_last_hop,
    output logic                               m_range_error
);
    localparam int PW = $clog2(MAX_POPULATIONS);
    localparam int PC_W = $clog2(MAX_POPULATIONS + 1);
    localparam int CW = $clog2(MAX_MESH_DIM);
    localparam int DW = $clog2(MAX_MESH_DIM + 1);
    localparam int NB = NEURON_ID_BITS;
    localparam int VW = 40;
    localparam int QB = 22;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LD_RD, ST_LD_WAIT, ST_LD_DIV, ST_LD_WR,
        ST_SCAN, ST_SCAN_WAIT, ST_PREV_RD, ST_PREV_WAIT, ST_LPE, ST_LPE_DIV,
        ST_TILE_DIV, ST_X_DIV, ST_NEXT, ST_PLAN, ST_WALK, ST_ERR
    } state_t;

    state_t state_reg;
    logic [4:0] w_cfg_reg, h_cfg_reg, pc_cfg_reg;
    logic [6:0] ppt_cfg_reg;
    logic [16:0] npe_cfg_reg;
    logic torus_reg;

    logic fnc_reg;
    logic [PW-1:0] idx_reg;
    logic [NB-1:0] first_reg, last_reg, src_reg, dst_reg, cur_reg;
    logic side_reg;
    logic [PC_W-1:0] scan_reg;
    logic [PW-1:0] pop_reg;
    logic [NB:0] lid_reg;
    logic lneg_reg;
    logic [15:0] accprev_reg;

    logic [VW-1:0] dnum_reg;
    logic [VW-1:0] drem_reg;
    logic [QB-1:0] dquo_reg;
    logic [16:0] dden_reg;
    logic [4:0] dcnt_reg;

    logic [CW-1:0] sx_reg, sy_reg, dx_reg, dy_reg;
    logic [6:0] dl_reg, sl_reg;
    logic [CW-1:0] cx_reg, cy_reg;
    logic [DW-1:0] xs_reg, ys_reg;
    logic xup_reg, yup_reg;
    logic [7:0] ytile_reg;

    logic m_valid_reg;
    logic [7:0] m_tile_reg;
    logic [19:0] m_key_reg;
    logic [6:0] m_port_reg;
    logic m_last_reg, m_err_reg;

    logic [DW-1:0] w_eff, h_eff;
    logic [6:0] ppt_eff;
    logic [16:0] npe_eff;
    logic [PC_W-1:0] cnt_eff;

    always_comb begin
        w_eff = (w_cfg_reg == 5'd0) ? DW'(1) :
            ((32'(w_cfg_reg) > MAX_MESH_DIM) ? DW'(MAX_MESH_DIM) : DW'(w_cfg_reg));
        h_eff = (h_cfg_reg == 5'd0) ? DW'(1) :
            ((32'(h_cfg_reg) > MAX_MESH_DIM) ? DW'(MAX_MESH_DIM) : DW'(h_cfg_reg));
        ppt_eff = (ppt_cfg_reg == 7'd0) ? 7'd1 : ((ppt_cfg_reg > 7'd64) ? 7'd64 : ppt_cfg_reg);
        npe_eff = (npe_cfg_reg == 17'd0) ? 17'd1 :
            ((npe_cfg_reg > 17'd65536) ? 17'd65536 : npe_cfg_reg);
        cnt_eff = (32'(pc_cfg_reg) > MAX_POPULATIONS) ? PC_W'(MAX_POPULATIONS) :
            PC_W'(pc_cfg_reg);
    end

    // Three tables, one RAM each, with a shared read address.
    logic ram_we;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [NB-1:0] rd_first, rd_last;
    logic [15:0] rd_acc, acc_wdata;

    nrhe_ram #(.WIDTH(NB), .DEPTH(MAX_POPULATIONS)) u_first (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(first_reg),
        .raddr(ram_raddr), .rdata(rd_first));
    nrhe_ram #(.WIDTH(NB), .DEPTH(MAX_POPULATIONS)) u_last (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(last_reg),
        .raddr(ram_raddr), .rdata(rd_last));
    nrhe_ram #(.WIDTH(16), .DEPTH(MAX_POPULATIONS)) u_acc (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(acc_wdata),
        .raddr(ram_raddr), .rdata(rd_acc));

    // Restoring divider step.
    logic [VW:0] dtrial;
    logic [VW-1:0] drem_sh;
    always_comb begin
        drem_sh = {drem_reg[VW-2:0], dnum_reg[VW-1]};
        dtrial = {1'b0, drem_sh} - {{(VW-16){1'b0}}, dden_reg};
    end
    logic [VW-1:0] drem_nx;
    logic [QB-1:0] dquo_nx;
    always_comb begin
        if (!dtrial[VW]) begin
            drem_nx = dtrial[VW-1:0];
            dquo_nx = {dquo_reg[QB-2:0], 1'b1};
        end else begin
            drem_nx = drem_sh;
            dquo_nx = {dquo_reg[QB-2:0], 1'b0};
        end
    end

    logic [16:0] acc_sum;
    logic [NB:0] lid_calc;
    logic [NB:0] lid_mag;
    logic match;
    logic signed [23:0] gpe;
    logic signed [CW+1:0] ddx, ddy;
    logic [DW-1:0] xs_n, ys_n;
    logic xup_n, yup_n;
    logic [7:0] hop_tile;

    always_comb begin
        acc_sum = {1'b0, (idx_reg == '0) ? 16'd0 : rd_acc} + 17'(dquo_reg);
        acc_wdata = (acc_sum > 17'hFFFF || dquo_reg > QB'(17'hFFFF)) ? 16'hFFFF :
            acc_sum[15:0];
        match = (cur_reg >= rd_first) && (cur_reg <= rd_last);
        lid_calc = (pop_reg == '0) ? {1'b0, cur_reg} : ({1'b0, cur_reg} - {1'b0, rd_last});
        lid_mag = lid_calc[NB] ? (~lid_calc + 1'b1) : lid_calc;
        if (lneg_reg) begin
            gpe = 24'(accprev_reg) - 24'(dquo_reg);
        end else begin
            gpe = 24'(accprev_reg) + 24'(dquo_reg);
        end
        ddx = (CW+2)'(dx_reg) - (CW+2)'(sx_reg);
        ddy = (CW+2)'(dy_reg) - (CW+2)'(sy_reg);
        xs_n = '0; xup_n = 1'b1; ys_n = '0; yup_n = 1'b1;
        if (torus_reg && ((ddx > 0 && 32'(ddx) > 32'(w_eff) / 2) ||
                (ddx < 0 && 32'(-ddx) > 32'(w_eff) / 2))) begin
            if (ddx > 0) begin
                xs_n = DW'(w_eff - DW'(ddx)); xup_n = 1'b0;
            end else begin
                xs_n = DW'(w_eff + DW'(ddx)); xup_n = 1'b1;
            end
        end else if (ddx >= 0) begin
            xs_n = DW'(ddx); xup_n = 1'b1;
        end else begin
            xs_n = DW'(-ddx); xup_n = 1'b0;
        end
        if (torus_reg && ((ddy > 0 && 32'(ddy) > 32'(h_eff) / 2) ||
                (ddy < 0 && 32'(-ddy) > 32'(h_eff) / 2))) begin
            if (ddy > 0) begin
                ys_n = DW'(h_eff - DW'(ddy)); yup_n = 1'b0;
            end else begin
                ys_n = DW'(h_eff + DW'(ddy)); yup_n = 1'b1;
            end
        end else if (ddy >= 0) begin
            ys_n = DW'(ddy); yup_n = 1'b1;
        end else begin
            ys_n = DW'(-ddy); yup_n = 1'b0;
        end
        hop_tile = ytile_reg + 8'(cx_reg);
    end

    assign ram_raddr = (state_reg == ST_SCAN || state_reg == ST_IDLE) ? scan_reg[PW-1:0] :
        ((fnc_reg == nrhe_pkg::FUNC_LOAD) ? PW'(idx_reg - 1'b1) : PW'(pop_reg - 1'b1));
    assign ram_we = (state_reg == ST_LD_WR);
    assign ram_waddr = idx_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            w_cfg_reg <= 5'd4; h_cfg_reg <= 5'd4; ppt_cfg_reg <= 7'd4;
            npe_cfg_reg <= 17'd256; torus_reg <= 1'b0; pc_cfg_reg <= 5'd0;
            m_valid_reg <= 1'b0;
            scan_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    nrhe_pkg::REG_MESH_WIDTH: w_cfg_reg <= cfg_data[4:0];
                    nrhe_pkg::REG_MESH_HEIGHT: h_cfg_reg <= cfg_data[4:0];
                    nrhe_pkg::REG_PES_PER_TILE: ppt_cfg_reg <= cfg_data[6:0];
                    nrhe_pkg::REG_NEURONS_PER_PE: npe_cfg_reg <= cfg_data;
                    nrhe_pkg::REG_TORUS_MODE: torus_reg <= cfg_data[0];
                    nrhe_pkg::REG_POP_COUNT: pc_cfg_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != ST_WALK && state_reg != ST_ERR) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    scan_reg <= '0;
                    if (s_valid) begin
                        fnc_reg <= s_func;
                        idx_reg <= PW'(s_pop_index);
                        first_reg <= NB'(s_pop_first_id);
                        last_reg <= NB'(s_pop_last_id);
                        src_reg <= NB'(s_src_neuron);
                        dst_reg <= NB'(s_dst_neuron);
                        cur_reg <= NB'(s_src_neuron);
                        side_reg <= 1'b0;
                        pop_reg <= '0;
                        if (s_func == nrhe_pkg::FUNC_LOAD) begin
                            state_reg <= (32'(s_pop_index) >= MAX_POPULATIONS) ? ST_IDLE
                                : ST_LD_RD;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_LD_RD: begin
                    if (last_reg >= first_reg) begin
                        dnum_reg <= VW'({1'b0, last_reg} - {1'b0, first_reg}) + VW'(npe_eff);
                    end else begin
                        dnum_reg <= '0;
                    end
                    drem_reg <= '0; dquo_reg <= '0;
                    dden_reg <= npe_eff;
                    dcnt_reg <= '0;
                    state_reg <= ST_LD_WAIT;
                end
                ST_LD_WAIT: begin
                    dnum_reg <= dnum_reg << (VW - QB);
                    state_reg <= ST_LD_DIV;
                end
                ST_LD_DIV: begin
                    drem_reg <= drem_nx; dquo_reg <= dquo_nx;
                    dnum_reg <= dnum_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 5'(QB - 1)) begin
                        state_reg <= ST_LD_WR;
                    end
                end
                ST_LD_WR: begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (scan_reg >= cnt_eff) begin
                        state_reg <= ST_PREV_RD;
                    end else begin
                        state_reg <= ST_SCAN_WAIT;
                    end
                end
                ST_SCAN_WAIT: begin
                    if (match) begin
                        pop_reg <= scan_reg[PW-1:0];
                    end
                    scan_reg <= scan_reg + 1'b1;
                    state_reg <= ST_SCAN;
                end
                ST_PREV_RD: begin
                    state_reg <= ST_PREV_WAIT;
                end
                ST_PREV_WAIT: begin
                    lid_reg <= lid_mag;
                    lneg_reg <= lid_calc[NB];
                    accprev_reg <= (pop_reg == '0) ? 16'd0 : rd_acc;
                    state_reg <= ST_LPE;
                end
                ST_LPE: begin
                    if (lneg_reg) begin
                        dnum_reg <= VW'(lid_reg) << (VW - QB);
                    end else if (lid_reg != '0) begin
                        dnum_reg <= (VW'(lid_reg) + VW'(npe_eff) - 1'b1) << (VW - QB);
                    end else begin
                        dnum_reg <= '0;
                    end
                    drem_reg <= '0; dquo_reg <= '0;
                    dden_reg <= npe_eff;
                    dcnt_reg <= '0;
                    state_reg <= ST_LPE_DIV;
                end
                ST_LPE_DIV: begin
                    drem_reg <= drem_nx; dquo_reg <= dquo_nx;
                    dnum_reg <= dnum_reg << 1;
                    if (dcnt_reg == 5'(QB - 1)) begin
                        state_reg <= ST_TILE_DIV;
                        dcnt_reg <= '0;
                    end else begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                ST_TILE_DIV: begin
                    if (dcnt_reg == '0) begin
                        if (gpe < 1) begin
                            state_reg <= ST_ERR;
                        end else begin
                            dnum_reg <= VW'(gpe - 1) << (VW - QB);
                            drem_reg <= '0; dquo_reg <= '0;
                            dden_reg <= 17'(ppt_eff);
                            dcnt_reg <= 5'd1;
                        end
                    end else if (dcnt_reg == 5'(QB)) begin
                        sl_reg <= 7'(drem_nx);
                        dnum_reg <= VW'(dquo_nx) << (VW - QB);
                        drem_reg <= '0; dquo_reg <= '0;
                        dden_reg <= 17'(w_eff);
                        dcnt_reg <= '0;
                        state_reg <= ST_X_DIV;
                    end else begin
                        drem_reg <= drem_nx; dquo_reg <= dquo_nx;
                        dnum_reg <= dnum_reg << 1;
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                ST_X_DIV: begin
                    drem_reg <= drem_nx; dquo_reg <= dquo_nx;
                    dnum_reg <= dnum_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 5'(QB - 1)) begin
                        if (dquo_nx >= QB'(h_eff)) begin
                            state_reg <= ST_ERR;
                        end else begin
                            if (!side_reg) begin
                                sx_reg <= CW'(drem_nx); sy_reg <= CW'(dquo_nx);
                            end else begin
                                dx_reg <= CW'(drem_nx); dy_reg <= CW'(dquo_nx);
                                dl_reg <= sl_reg;
                            end
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT: begin
                    if (!side_reg) begin
                        side_reg <= 1'b1;
                        cur_reg <= dst_reg;
                        scan_reg <= '0;
                        pop_reg <= '0;
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    xs_reg <= xs_n; xup_reg <= xup_n;
                    ys_reg <= ys_n; yup_reg <= yup_n;
                    cx_reg <= sx_reg; cy_reg <= sy_reg;
                    ytile_reg <= 8'(32'(sy_reg) * 32'(w_eff));
                    state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_key_reg <= 20'(src_reg);
                        m_err_reg <= 1'b0;
                        m_tile_reg <= hop_tile;
                        if (xs_reg != '0) begin
                            m_port_reg <= xup_reg ? nrhe_pkg::PORT_EAST : nrhe_pkg::PORT_WEST;
                            m_last_reg <= 1'b0;
                            xs_reg <= xs_reg - 1'b1;
                            if (xup_reg) begin
                                cx_reg <= (DW'(cx_reg) + 1'b1 == w_eff) ? '0 : cx_reg + 1'b1;
                            end else begin
                                cx_reg <= (cx_reg == '0) ? CW'(w_eff - 1'b1) : cx_reg - 1'b1;
                            end
                        end else if (ys_reg != '0) begin
                            m_port_reg <= yup_reg ? nrhe_pkg::PORT_SOUTH : nrhe_pkg::PORT_NORTH;
                            m_last_reg <= 1'b0;
                            ys_reg <= ys_reg - 1'b1;
                            if (yup_reg) begin
                                if (DW'(cy_reg) + 1'b1 == h_eff) begin
                                    cy_reg <= '0; ytile_reg <= '0;
                                end else begin
                                    cy_reg <= cy_reg + 1'b1;
                                    ytile_reg <= ytile_reg + 8'(w_eff);
                                end
                            end else begin
                                if (cy_reg == '0) begin
                                    cy_reg <= CW'(h_eff - 1'b1);
                                    ytile_reg <= 8'(32'(h_eff - 1'b1) * 32'(w_eff));
                                end else begin
                                    cy_reg <= cy_reg - 1'b1;
                                    ytile_reg <= ytile_reg - 8'(w_eff);
                                end
                            end
                        end else begin
                            m_port_reg <= nrhe_pkg::PORT_LOCAL + dl_reg;
                            m_last_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_ERR: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_key_reg <= 20'(src_reg);
                        m_tile_reg <= '0;
                        m_port_reg <= nrhe_pkg::PORT_NORTH;
                        m_last_reg <= 1'b1;
                        m_err_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_tile_index = m_tile_reg;
    assign m_key_neuron = m_key_reg;
    assign m_out_port = m_port_reg;
    assign m_last_hop = m_last_reg;
    assign m_range_error = m_err_reg;
endmodule

// ----- hw/rtl/nrhe_checker.sv -----
// Port-level checker for the neuron route hop expander, bound to the top level.
// Depends on nrhe_pkg and neuron_route_hop_expander_top.
module nrhe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_out_port,
    input logic       m_last_hop,
    input logic       m_range_error
);
    // An error result is always the only and final result of its route, and it names the north port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_last_hop && m_out_port == nrhe_pkg::PORT_NORTH)
        else $error("error result malformed");
    // A hop that is not the last never names a local port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_hop |-> m_out_port < nrhe_pkg::PORT_LOCAL)
        else $error("intermediate hop uses a local port");
    // A final entry without error names a local port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_hop && !m_range_error |-> m_out_port >= nrhe_pkg::PORT_LOCAL)
        else $error("final entry lacks local port");
    // A result is held until its transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_port))
        else $error("result dropped while stalled");
    // No item is taken while the output still shows a non-final hop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_hop |-> !s_ready)
        else $error("input accepted mid-route");
endmodule

bind neuron_route_hop_expander_top nrhe_checker u_nrhe_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_out_port(m_out_port),
    .m_last_hop(m_last_hop), .m_range_error(m_range_error));
